/* sv/v3a_pkg.sv */
// Shared types, widths, action and status codes for the vector3 fixed-point ALU.
// No dependencies; used by every module of the block.
`default_nettype none

package v3a_pkg;

  localparam int W      = 32;           // word width
  localparam int F      = 16;           // fraction bits
  localparam int QW     = W + F;        // divider quotient width / divider steps
  localparam int WIDE   = 2 * W + 2;    // exact width of sums of products
  localparam int AW     = 4;            // action code width
  localparam int SW     = 2;            // status width
  localparam int IN_DW  = ((7 * W + 7) / 8) * 8;
  localparam int OUT_DW = ((4 * W + 7) / 8) * 8;

  localparam logic [AW-1:0] ACT_ADD   = 4'd0;
  localparam logic [AW-1:0] ACT_SUB   = 4'd1;
  localparam logic [AW-1:0] ACT_SCALE = 4'd2;
  localparam logic [AW-1:0] ACT_DIV   = 4'd3;
  localparam logic [AW-1:0] ACT_DOT   = 4'd4;
  localparam logic [AW-1:0] ACT_CROSS = 4'd5;
  localparam logic [AW-1:0] ACT_SQ    = 4'd6;
  localparam logic [AW-1:0] ACT_MAG   = 4'd7;
  localparam logic [AW-1:0] ACT_DIST  = 4'd8;

  localparam logic [SW-1:0] ST_OK   = 2'd0;
  localparam logic [SW-1:0] ST_DIVZ = 2'd1;
  localparam logic [SW-1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [W-1:0] v;
    logic         s;
  } sat_t;

  // State carried through the divide / square-root step chain.
  typedef struct packed {
    logic [AW-1:0]         act;
    logic                  sat;
    logic                  dz;
    logic [2:0]            neg;
    logic [2:0][W-1:0]     rem;
    logic [2:0][QW-1:0]    nq;     // numerator shifting out, quotient shifting in
    logic [W-1:0]          dm;
    logic [W-1:0]          root;
    logic [W+1:0]          srem;
    logic [2*W-1:0]        srad;
    logic [3:0][W-1:0]     res;    // x, y, z, scalar for actions done up front
  } iter_t;

  // Clamp an exact value into the signed word range.
  function automatic sat_t sat_word(input logic signed [WIDE-1:0] x);
    sat_t r;
    if (x[WIDE-1:W-1] == '0 || x[WIDE-1:W-1] == '1) begin
      r.v = x[W-1:0];
      r.s = 1'b0;
    end else begin
      r.s = 1'b1;
      r.v = x[WIDE-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/v3a_front.sv */
// Front pipeline: add/sub, six multipliers, product sums, fraction shift with
// saturation, and setup of the divide / square-root chain. Depends on v3a_pkg.
`default_nettype none

module v3a_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [v3a_pkg::AW-1:0]     act,
  input  wire logic [7*v3a_pkg::W-1:0]    data,
  output logic                            out_valid,
  output v3a_pkg::iter_t                  out
);

  localparam int W    = v3a_pkg::W;
  localparam int F    = v3a_pkg::F;
  localparam int WIDE = v3a_pkg::WIDE;

  // stage 1: captured request
  logic                       v1;
  logic [v3a_pkg::AW-1:0]     act1;
  logic signed [W-1:0]        a1 [3];
  logic signed [W-1:0]        b1 [3];
  logic signed [W-1:0]        sc1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1 <= act;
      for (int i = 0; i < 3; i++) begin
        a1[i] <= data[i*W +: W];
        b1[i] <= data[(i+3)*W +: W];
      end
      sc1 <= data[6*W +: W];
    end
  end

  v3a_pkg::sat_t add_s [3];
  v3a_pkg::sat_t sub_s [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      add_s[i] = v3a_pkg::sat_word(WIDE'(a1[i]) + WIDE'(b1[i]));
      sub_s[i] = v3a_pkg::sat_word(WIDE'(a1[i]) - WIDE'(b1[i]));
    end
  end

  // stage 2: saturated sums and differences
  logic                       v2;
  logic [v3a_pkg::AW-1:0]     act2;
  logic signed [W-1:0]        a2 [3];
  logic signed [W-1:0]        b2 [3];
  logic signed [W-1:0]        sc2;
  logic signed [W-1:0]        addr2 [3];
  logic signed [W-1:0]        subr2 [3];
  logic                       adds2, subs2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act2 <= act1;
      sc2  <= sc1;
      for (int i = 0; i < 3; i++) begin
        a2[i]    <= a1[i];
        b2[i]    <= b1[i];
        addr2[i] <= add_s[i].v;
        subr2[i] <= sub_s[i].v;
      end
      adds2 <= add_s[0].s | add_s[1].s | add_s[2].s;
      subs2 <= sub_s[0].s | sub_s[1].s | sub_s[2].s;
    end
  end

  // operand select: p = opa*opb, q = opc*opd (q only for cross)
  logic signed [W-1:0] opa [3];
  logic signed [W-1:0] opb [3];
  logic signed [W-1:0] opc [3];
  logic signed [W-1:0] opd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[i] = a2[i];
      opb[i] = a2[i];
      opc[i] = a2[i];
      opd[i] = b2[i];
    end
    case (act2)
      v3a_pkg::ACT_SCALE: begin
        for (int i = 0; i < 3; i++) opb[i] = sc2;
      end
      v3a_pkg::ACT_DOT: begin
        for (int i = 0; i < 3; i++) opb[i] = b2[i];
      end
      v3a_pkg::ACT_CROSS: begin
        opa[0] = a2[1]; opb[0] = b2[2]; opc[0] = a2[2]; opd[0] = b2[1];
        opa[1] = a2[2]; opb[1] = b2[0]; opc[1] = a2[0]; opd[1] = b2[2];
        opa[2] = a2[0]; opb[2] = b2[1]; opc[2] = a2[1]; opd[2] = b2[0];
      end
      v3a_pkg::ACT_DIST: begin
        for (int i = 0; i < 3; i++) begin
          opa[i] = subr2[i];
          opb[i] = subr2[i];
        end
      end
      default: begin
      end
    endcase
  end

  // stage 3: products
  logic                       v3;
  logic [v3a_pkg::AW-1:0]     act3;
  logic signed [2*W-1:0]      p3 [3];
  logic signed [2*W-1:0]      q3 [3];
  logic signed [W-1:0]        a3 [3];
  logic signed [W-1:0]        sc3;
  logic signed [W-1:0]        addr3 [3];
  logic signed [W-1:0]        subr3 [3];
  logic                       adds3, subs3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act3  <= act2;
      sc3   <= sc2;
      adds3 <= adds2;
      subs3 <= subs2;
      for (int i = 0; i < 3; i++) begin
        p3[i]    <= opa[i] * opb[i];
        q3[i]    <= opc[i] * opd[i];
        a3[i]    <= a2[i];
        addr3[i] <= addr2[i];
        subr3[i] <= subr2[i];
      end
    end
  end

  logic signed [WIDE-1:0] w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) w[i] = WIDE'(p3[i]);
    case (act3)
      v3a_pkg::ACT_CROSS: begin
        for (int i = 0; i < 3; i++) w[i] = WIDE'(p3[i]) - WIDE'(q3[i]);
      end
      v3a_pkg::ACT_DOT, v3a_pkg::ACT_SQ, v3a_pkg::ACT_MAG, v3a_pkg::ACT_DIST: begin
        w[0] = WIDE'(p3[0]) + WIDE'(p3[1]) + WIDE'(p3[2]);
      end
      default: begin
      end
    endcase
  end

  // stage 4: exact sums
  logic                       v4;
  logic [v3a_pkg::AW-1:0]     act4;
  logic signed [WIDE-1:0]     w4 [3];
  logic signed [W-1:0]        a4 [3];
  logic signed [W-1:0]        sc4;
  logic signed [W-1:0]        addr4 [3];
  logic signed [W-1:0]        subr4 [3];
  logic                       adds4, subs4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act4  <= act3;
      sc4   <= sc3;
      adds4 <= adds3;
      subs4 <= subs3;
      for (int i = 0; i < 3; i++) begin
        w4[i]    <= w[i];
        a4[i]    <= a3[i];
        addr4[i] <= addr3[i];
        subr4[i] <= subr3[i];
      end
    end
  end

  v3a_pkg::sat_t sh [3];
  logic [W-1:0]  am [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = v3a_pkg::sat_word(w4[i] >>> F);
      am[i] = a4[i][W-1] ? W'(-a4[i]) : W'(a4[i]);
    end
    out      = '0;
    out.act  = act4;
    out.dm   = sc4[W-1] ? W'(-sc4) : W'(sc4);
    out.srad = w4[0][2*W-1:0];
    for (int i = 0; i < 3; i++) begin
      out.nq[i]  = {am[i], {F{1'b0}}};
      out.neg[i] = a4[i][W-1] ^ sc4[W-1];
    end
    case (act4)
      v3a_pkg::ACT_ADD: begin
        for (int i = 0; i < 3; i++) out.res[i] = addr4[i];
        out.sat = adds4;
      end
      v3a_pkg::ACT_SUB: begin
        for (int i = 0; i < 3; i++) out.res[i] = subr4[i];
        out.sat = subs4;
      end
      v3a_pkg::ACT_SCALE, v3a_pkg::ACT_CROSS: begin
        for (int i = 0; i < 3; i++) out.res[i] = sh[i].v;
        out.sat = sh[0].s | sh[1].s | sh[2].s;
      end
      v3a_pkg::ACT_DOT, v3a_pkg::ACT_SQ: begin
        out.res[3] = sh[0].v;
        out.sat    = sh[0].s;
      end
      v3a_pkg::ACT_DIV: begin
        out.dz = (sc4 == '0);
      end
      v3a_pkg::ACT_DIST: begin
        out.sat = subs4;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = v4;

endmodule

`default_nettype wire

/* sv/v3a_iter.sv */
// One registered step of the divide chain (three restoring-divide lanes)
// and of the digit-by-digit square root. Depends on v3a_pkg.
`default_nettype none

module v3a_iter (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           sqrt_on,
  input  wire logic           in_valid,
  input  v3a_pkg::iter_t      in,
  output logic                out_valid,
  output v3a_pkg::iter_t      out
);

  localparam int W  = v3a_pkg::W;
  localparam int QW = v3a_pkg::QW;

  v3a_pkg::iter_t nxt;
  logic [W:0]     t [3];
  logic [W:0]     d [3];
  logic [W+3:0]   st, tr, sd;

  always_comb begin
    nxt = in;
    for (int i = 0; i < 3; i++) begin
      t[i] = {in.rem[i], in.nq[i][QW-1]};
      d[i] = t[i] - {1'b0, in.dm};
      if (t[i] >= {1'b0, in.dm}) begin
        nxt.rem[i] = d[i][W-1:0];
        nxt.nq[i]  = {in.nq[i][QW-2:0], 1'b1};
      end else begin
        nxt.rem[i] = t[i][W-1:0];
        nxt.nq[i]  = {in.nq[i][QW-2:0], 1'b0};
      end
    end
    st = {in.srem, in.srad[2*W-1:2*W-2]};
    tr = {2'b00, in.root, 2'b01};
    sd = st - tr;
    if (sqrt_on) begin
      nxt.srad = {in.srad[2*W-3:0], 2'b00};
      if (st >= tr) begin
        nxt.srem = sd[W+1:0];
        nxt.root = {in.root[W-2:0], 1'b1};
      end else begin
        nxt.srem = st[W+1:0];
        nxt.root = {in.root[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) out <= nxt;
  end

endmodule

`default_nettype wire

/* sv/vector3_fixed_alu_unit.sv */
// Top level of the vector3 fixed-point ALU: front pipeline, divide/root
// step chain, result select and output skid buffer. Depends on v3a_pkg,
// v3a_front and v3a_iter.
//
// Usage:
//  - Request channel s_*: s_tuser carries the action code, s_tdata the two
//    vectors and the scalar (Q16.16). A request is taken on s_tvalid & s_tready.
//  - Result channel m_*: m_tdata carries the result vector and scalar,
//    m_tuser the status (ok, divide by zero, saturated). One result per request,
//    in request order.
//  - Path: the accepting edge fills the first of 4 front stages, then 48 divider
//    steps, which also host the 32 square-root steps, then the output register.
//    Same path for every action.
//  - Throughput: one request per cycle while s_tready is high. The 48-step divider chain sets the
//    latency; each step is one compare/subtract per lane.
//  - Stall: a two-entry output (register plus skid) absorbs a result when
//    m_tready is low; the pipeline freezes only once the skid entry is full,
//    and s_tready then drops. Nothing is lost or repeated.
//  - Reset (rst, synchronous): clears all valid bits and the output buffer.
`default_nettype none

module vector3_fixed_alu_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scalar (32 bits each, lowest first)
  input  wire logic [v3a_pkg::IN_DW-1:0]      s_tdata,
  // action
  input  wire logic [v3a_pkg::AW-1:0]         s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // r_x, r_y, r_z, r_scalar (32 bits each, lowest first)
  output logic [v3a_pkg::OUT_DW-1:0]          m_tdata,
  // status
  output logic [v3a_pkg::SW-1:0]              m_tuser
);

  localparam int W  = v3a_pkg::W;
  localparam int QW = v3a_pkg::QW;
  localparam logic [QW-1:0] Q_MAX  = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] Q_MINM = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  W_MAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  W_MIN  = {1'b1, {(W-1){1'b0}}};

  logic en;
  logic skid_full;

  // whole pipeline advances unless the skid entry is occupied
  assign en       = ~skid_full;
  assign s_tready = en;

  v3a_pkg::iter_t chain [QW+1];
  logic           cv    [QW+1];

  v3a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .act       (s_tuser),
    .data      (s_tdata[7*W-1:0]),
    .out_valid (cv[0]),
    .out       (chain[0])
  );

  // first W steps also run the square root (one root bit per step)
  for (genvar g = 0; g < QW; g++) begin : g_step
    v3a_iter u_iter (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .sqrt_on   ((g < W) ? 1'b1 : 1'b0),
      .in_valid  (cv[g]),
      .in        (chain[g]),
      .out_valid (cv[g+1]),
      .out       (chain[g+1])
    );
  end

  // result select at the end of the chain
  v3a_pkg::iter_t          f;
  logic [3:0][W-1:0]       r;
  logic                    sat;
  logic [v3a_pkg::SW-1:0]  st;
  logic [QW-1:0]           qneg;

  assign f = chain[QW];

  always_comb begin
    r    = '0;
    sat  = f.sat;
    qneg = '0;
    case (f.act)
      v3a_pkg::ACT_DIV: begin
        if (!f.dz) begin
          for (int i = 0; i < 3; i++) begin
            qneg = ~f.nq[i] + 1'b1;
            if (f.neg[i]) begin
              if (f.nq[i] > Q_MINM) begin
                r[i] = W_MIN;
                sat  = 1'b1;
              end else begin
                r[i] = qneg[W-1:0];
              end
            end else begin
              if (f.nq[i] > Q_MAX) begin
                r[i] = W_MAX;
                sat  = 1'b1;
              end else begin
                r[i] = f.nq[i][W-1:0];
              end
            end
          end
        end
      end
      v3a_pkg::ACT_MAG, v3a_pkg::ACT_DIST: begin
        if (f.root[W-1]) begin
          r[3] = W_MAX;
          sat  = 1'b1;
        end else begin
          r[3] = f.root;
        end
      end
      default: begin
        r = f.res;
      end
    endcase
    if (f.dz) st = v3a_pkg::ST_DIVZ;
    else if (sat) st = v3a_pkg::ST_SAT;
    else st = v3a_pkg::ST_OK;
  end

  // output register and skid entry
  logic [v3a_pkg::OUT_DW-1:0] res_data;
  logic [v3a_pkg::OUT_DW-1:0] skid_data;
  logic [v3a_pkg::SW-1:0]     skid_user;
  logic                       vl;

  assign res_data = v3a_pkg::OUT_DW'(r);
  assign vl       = cv[QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (m_tready) skid_full <= 1'b0;
    end else if (vl) begin
      if (!m_tvalid || m_tready) m_tvalid <= 1'b1;
      else skid_full <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (m_tready) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end
    end else if (vl) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= res_data;
        m_tuser <= st;
      end else begin
        skid_data <= res_data;
        skid_user <= st;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_blocks_in: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> !s_tready) else $error("request taken with skid entry full");

  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> m_tvalid) else $error("skid entry full without a held result");

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == v3a_pkg::ST_DIVZ) |-> m_tdata == '0)
    else $error("divide by zero result not cleared");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == v3a_pkg::ST_OK || m_tuser == v3a_pkg::ST_DIVZ ||
                  m_tuser == v3a_pkg::ST_SAT))
    else $error("unknown status code");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for vector3_fixed_alu_unit: directed and random requests,
// bursty sender, stalling receiver, in-order scoreboard. Depends on v3a_pkg.
`timescale 1ns / 100ps

module testbench;
  localparam int W      = v3a_pkg::W;
  localparam int F      = v3a_pkg::F;
  localparam int AW     = v3a_pkg::AW;
  localparam int SW     = v3a_pkg::SW;
  localparam int IN_DW  = v3a_pkg::IN_DW;
  localparam int OUT_DW = v3a_pkg::OUT_DW;

  typedef struct packed {
    logic [W-1:0] x, y, z, s;
    logic [SW-1:0] st;
  } vres_t;

  // Expected-result store: predicts each request at acceptance, checks in order.
  class alu_scoreboard;
    vres_t pending[$];
    int errors;

    // report task: one line per mismatch, printed for the first 50 only
    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // 128-bit signed helpers
    static function logic signed [127:0] sx(logic [W-1:0] v);
      return {{(128-W){v[W-1]}}, v};
    endfunction

    static function logic [W-1:0] clamp(logic signed [127:0] v, inout bit s);
      if (v > sx({1'b0, {(W-1){1'b1}}})) begin s = 1; return {1'b0, {(W-1){1'b1}}}; end
      if (v < sx({1'b1, {(W-1){1'b0}}})) begin s = 1; return {1'b1, {(W-1){1'b0}}}; end
      return v[W-1:0];
    endfunction

    static function logic [127:0] root_floor(logic [127:0] n);
      logic [127:0] root, rem, trial;
      root = 0; rem = 0;
      for (int i = 63; i >= 0; i--) begin
        rem = (rem << 2) | ((n >> (2 * i)) & 128'd3);
        trial = (root << 2) | 128'd1;
        if (rem >= trial) begin rem = rem - trial; root = (root << 1) | 1; end
        else root = root << 1;
      end
      return root;
    endfunction

    static function logic [W-1:0] length_of(logic [W-1:0] x, y, z, inout bit s);
      logic signed [127:0] q;
      logic [127:0] r;
      q = sx(x) * sx(x) + sx(y) * sx(y) + sx(z) * sx(z);
      r = root_floor(q);
      if (r > {1'b0, {(W-1){1'b1}}}) begin s = 1; return {1'b0, {(W-1){1'b1}}}; end
      return r[W-1:0];
    endfunction

    static function logic [W-1:0] quot(logic [W-1:0] a, d, inout bit s);
      logic signed [127:0] n;
      n = sx(a) <<< F;
      return clamp(n / sx(d), s); // SV division truncates toward zero
    endfunction

    function vres_t predict(logic [AW-1:0] act, logic [W-1:0] v[7]);
      vres_t r;
      bit s;
      logic signed [127:0] t;
      logic [W-1:0] dx, dy, dz;
      r = '0; s = 0;
      case (act)
        v3a_pkg::ACT_ADD: begin
          r.x = clamp(sx(v[0]) + sx(v[3]), s);
          r.y = clamp(sx(v[1]) + sx(v[4]), s);
          r.z = clamp(sx(v[2]) + sx(v[5]), s);
        end
        v3a_pkg::ACT_SUB: begin
          r.x = clamp(sx(v[0]) - sx(v[3]), s);
          r.y = clamp(sx(v[1]) - sx(v[4]), s);
          r.z = clamp(sx(v[2]) - sx(v[5]), s);
        end
        v3a_pkg::ACT_SCALE: begin
          r.x = clamp((sx(v[0]) * sx(v[6])) >>> F, s);
          r.y = clamp((sx(v[1]) * sx(v[6])) >>> F, s);
          r.z = clamp((sx(v[2]) * sx(v[6])) >>> F, s);
        end
        v3a_pkg::ACT_DIV: begin
          if (v[6] == 0) r.st = v3a_pkg::ST_DIVZ;
          else begin
            r.x = quot(v[0], v[6], s);
            r.y = quot(v[1], v[6], s);
            r.z = quot(v[2], v[6], s);
          end
        end
        v3a_pkg::ACT_DOT: begin
          t = sx(v[0]) * sx(v[3]) + sx(v[1]) * sx(v[4]) + sx(v[2]) * sx(v[5]);
          r.s = clamp(t >>> F, s);
        end
        v3a_pkg::ACT_CROSS: begin
          r.x = clamp((sx(v[1]) * sx(v[5]) - sx(v[2]) * sx(v[4])) >>> F, s);
          r.y = clamp((sx(v[2]) * sx(v[3]) - sx(v[0]) * sx(v[5])) >>> F, s);
          r.z = clamp((sx(v[0]) * sx(v[4]) - sx(v[1]) * sx(v[3])) >>> F, s);
        end
        v3a_pkg::ACT_SQ: begin
          t = sx(v[0]) * sx(v[0]) + sx(v[1]) * sx(v[1]) + sx(v[2]) * sx(v[2]);
          r.s = clamp(t >>> F, s);
        end
        v3a_pkg::ACT_MAG: r.s = length_of(v[0], v[1], v[2], s);
        v3a_pkg::ACT_DIST: begin
          dx = clamp(sx(v[0]) - sx(v[3]), s);
          dy = clamp(sx(v[1]) - sx(v[4]), s);
          dz = clamp(sx(v[2]) - sx(v[5]), s);
          r.s = length_of(dx, dy, dz, s);
        end
        default: ;
      endcase
      if (r.st == v3a_pkg::ST_OK && s) r.st = v3a_pkg::ST_SAT;
      return r;
    endfunction

    function void note_request(logic [AW-1:0] act, logic [W-1:0] v[7]);
      pending.push_back(predict(act, v));
    endfunction

    task check_result(vres_t got);
      vres_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no request pending");
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) report_mismatch($sformatf("r_x %h exp %h", got.x, e.x));
      if (got.y !== e.y) report_mismatch($sformatf("r_y %h exp %h", got.y, e.y));
      if (got.z !== e.z) report_mismatch($sformatf("r_z %h exp %h", got.z, e.z));
      if (got.s !== e.s) report_mismatch($sformatf("r_scalar %h exp %h", got.s, e.s));
      if (got.st !== e.st) report_mismatch($sformatf("status %0d exp %0d", got.st, e.st));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic [IN_DW-1:0] s_tdata = '0;
  logic [AW-1:0] s_tuser = '0;
  logic s_tready, m_tvalid;
  logic [OUT_DW-1:0] m_tdata;
  logic [SW-1:0] m_tuser;

  alu_scoreboard sb = new();
  bit hold_off = 0;     // long receiver stall

  vector3_fixed_alu_unit u_dut (.*);

  initial forever #10 clk = ~clk;

  // Offer one request and wait until it is taken.
  task automatic send_request(logic [AW-1:0] act, logic [W-1:0] v[7]);
    logic [IN_DW-1:0] d;
    d = '0;
    for (int i = 0; i < 7; i++) d[i*W +: W] = v[i];
    s_tvalid <= 1;
    s_tdata <= d;
    s_tuser <= act;
    do @(posedge clk); while (!s_tready);
    sb.note_request(act, v);
  endtask

  task automatic go_idle(int n);
    s_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // Random word biased toward edges and small values.
  function automatic logic [W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 3) << 16;
      3: return -($urandom_range(0, 3) << 16);
      4, 5: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(logic [AW-1:0] act);
    logic [W-1:0] v[7];
    foreach (v[i]) v[i] = pick_word();
    if (act == v3a_pkg::ACT_DIV && $urandom_range(0, 15) == 0) v[6] = 0;
    send_request(act, v);
  endtask

  // Receiver: own stall pattern, plus a long hold-off on request.
  initial begin
    int mode;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        if (hold_off) m_tready <= 0;
        else case (mode)
          0: m_tready <= 1;
          1: m_tready <= $urandom_range(0, 1);
          2: m_tready <= ($urandom_range(0, 4) != 0);
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result({m_tdata[0 +: W], m_tdata[W +: W], m_tdata[2*W +: W],
                       m_tdata[3*W +: W], m_tuser});
  end

  // Stimulus
  initial begin
    logic [W-1:0] v[7];
    bit drained;
    drained = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every action at extremes, plus divide by zero and unused codes
    for (int a = 0; a <= 8; a++) begin
      foreach (v[i]) v[i] = 32'h7fffffff;
      send_request(AW'(a), v);
      foreach (v[i]) v[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
      send_request(AW'(a), v);
    end
    foreach (v[i]) v[i] = 32'h00010000;
    v[6] = 0;
    send_request(v3a_pkg::ACT_DIV, v);
    v[6] = 32'h00000001;
    send_request(v3a_pkg::ACT_DIV, v);
    send_request(4'd9, v);
    send_request(4'd15, v);
    foreach (v[i]) v[i] = 0;
    send_request(v3a_pkg::ACT_MAG, v);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      repeat (120) send_random(AW'($urandom_range(0, 8)));
    join

    // random bursts with gaps
    for (int n = 0; n < 1330; ) begin
      int len;
      len = $urandom_range(1, 40);
      for (int k = 0; k < len; k++, n++)
        send_random(($urandom_range(0, 19) == 0) ? AW'($urandom_range(9, 15))
                                                 : AW'($urandom_range(0, 8)));
      if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 15));
      // sender drains the pipeline once midway
      if (n > 600 && !drained) begin
        drained = 1;
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
      end
    end
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
